// ----- src/hrsp_pkg.sv -----
// Shared types, constants and helper functions for the HTTP response stream parser.
// No dependencies; every other file in src refers to this package by scoped names.

package hrsp_pkg;

  // Sizing
  localparam int SIZE_DIGITS = 4;                 // hex digits of a chunk size
  localparam int CODE_DIGITS = 3;                 // decimal digits of the status code
  localparam int CR_W        = 4 * SIZE_DIGITS;   // chunk byte counter width
  localparam int CODE_W      = 10;                // status code value width
  localparam int STAT_W      = 11;                // reported status field width
  localparam int CODE_MAX    = (CODE_DIGITS == 1) ? 9 : ((CODE_DIGITS == 2) ? 99 : 999);

  // Header match
  localparam int                  HDR_LEN    = 26;
  localparam logic [8*HDR_LEN-1:0] HDR_TEXT  = "Transfer-Encoding: chunked";
  localparam logic [4:0]          MATCH_FAIL = 5'd31;

  // Status digit counter code for "number finished"
  localparam logic [2:0] DIGITS_STOPPED = 3'd7;

  // Chunk decoding can make up to this many passes over one byte
  localparam int CHUNK_PASSES = 3;

  // Characters
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_UA   = 8'h41;
  localparam logic [7:0] CH_UF   = 8'h46;
  localparam logic [7:0] CH_LA   = 8'h61;
  localparam logic [7:0] CH_LF_F = 8'h66;

  // Result kinds
  localparam logic [1:0] KIND_STATUS  = 2'd0;
  localparam logic [1:0] KIND_CONTENT = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  // Item held in the input register
  typedef struct packed {
    logic       vld;
    logic [7:0] data;
    logic       last;
  } item_t;

  // Result produced by the parser step
  typedef struct packed {
    logic                     have;
    logic [1:0]               kind;
    logic signed [STAT_W-1:0] status;
    logic [7:0]               content_byte;
    logic                     final_res;
  } res_t;

  // Hex digit decode: {ok, value}
  function automatic logic [4:0] hex_decode(logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= CH_0 && b <= CH_9) begin
      r = {1'b1, 4'(b - CH_0)};
    end else if (b >= CH_UA && b <= CH_UF) begin
      r = {1'b1, 4'(b - CH_UA + 8'd10)};
    end else if (b >= CH_LA && b <= CH_LF_F) begin
      r = {1'b1, 4'(b - CH_LA + 8'd10)};
    end
    return r;
  endfunction

  // Character of the header text at a match position
  function automatic logic [7:0] hdr_char(logic [4:0] pos);
    logic [7:0] c;
    c = 8'd0;
    if (int'(pos) < HDR_LEN) begin
      c = HDR_TEXT[8*(HDR_LEN-1-int'(pos)) +: 8];
    end
    return c;
  endfunction

  // Append one hex digit to the chunk size, saturating at all ones
  function automatic logic [CR_W-1:0] size_step(logic [CR_W-1:0] cr, logic [3:0] h);
    logic [CR_W+3:0] v;
    v = {cr, h};
    if (v[CR_W+3:CR_W] != 4'd0) begin
      return {CR_W{1'b1}};
    end
    return v[CR_W-1:0];
  endfunction

endpackage

// ----- src/hrsp_in_stage.sv -----
// Input register of the parser: captures one byte transfer per cycle unless stalled.
// Depends on hrsp_pkg (item_t).

module hrsp_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_data_byte,
  input  logic          in_end_of_response,
  input  logic          room,
  output hrsp_pkg::item_t item
);

  logic       vld_r;
  logic [7:0] data_r;
  logic       last_r;

  // Hold while the held byte cannot move on
  assign in_stall = vld_r && !room;

  // Valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (!vld_r || room) begin
      vld_r <= in_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      data_r <= in_data_byte;
      last_r <= in_end_of_response;
    end
  end

  assign item.vld  = vld_r;
  assign item.data = data_r;
  assign item.last = last_r;

endmodule

// ----- src/hrsp_parser.sv -----
// Parser state and combinational next-state logic: status line, header scan, body
// and chunked decoding. Depends on hrsp_pkg (item_t, res_t, constants, functions).

module hrsp_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  hrsp_pkg::item_t item,
  input  logic            room,
  output hrsp_pkg::res_t  res
);

  typedef enum logic [2:0] {
    PH_VERSION, PH_CODE, PH_REASON, PH_HEADERS, PH_BODY, PH_SIZE, PH_DATA, PH_DONE
  } phase_t;

  phase_t                       phase_r, phase_nxt;
  logic [hrsp_pkg::CODE_W-1:0]  code_r, code_nxt;
  logic                         seen_r, seen_nxt;
  logic [4:0]                   hpos_r, hpos_nxt;
  logic [1:0]                   ll_r, ll_nxt;
  logic                         cronly_r, cronly_nxt;
  logic                         chunked_r, chunked_nxt;
  logic [hrsp_pkg::CR_W-1:0]    crem_r, crem_nxt;
  logic [2:0]                   dcnt_r, dcnt_nxt;

  logic       en;
  logic [7:0] b;
  logic [4:0] hx;
  logic       lf_empty;
  logic       have;
  logic [1:0] kind;
  logic [7:0] ob;
  logic [13:0] code_ext;

  assign en = item.vld && room;
  assign b  = item.data;
  assign hx = hrsp_pkg::hex_decode(item.data);
  // code * 10 + digit
  assign code_ext = ({4'd0, code_r} << 3) + ({4'd0, code_r} << 1) + {6'd0, b - hrsp_pkg::CH_0};

  // Next state and result for the held byte
  always_comb begin
    phase_t                    ph;
    logic [1:0]                ll;
    logic [hrsp_pkg::CR_W-1:0] cr;
    logic                      go;
    logic                      stat_ph;

    phase_nxt   = phase_r;
    code_nxt    = code_r;
    seen_nxt    = seen_r;
    hpos_nxt    = hpos_r;
    ll_nxt      = ll_r;
    cronly_nxt  = cronly_r;
    chunked_nxt = chunked_r;
    crem_nxt    = crem_r;
    dcnt_nxt    = dcnt_r;
    have        = 1'b0;
    kind        = hrsp_pkg::KIND_STATUS;
    ob          = 8'd0;
    lf_empty    = 1'b0;
    ph          = phase_r;
    ll          = ll_r;
    cr          = crem_r;
    go          = 1'b0;

    stat_ph = (phase_r == PH_VERSION) || (phase_r == PH_CODE) || (phase_r == PH_REASON);

    // Line tracking and header match in the status and header lines
    if (stat_ph || phase_r == PH_HEADERS) begin
      if (b == hrsp_pkg::CH_LF) begin
        lf_empty   = (ll_r == 2'd0) || (ll_r == 2'd1 && cronly_r);
        ll_nxt     = 2'd0;
        cronly_nxt = 1'b0;
        hpos_nxt   = 5'd0;
      end else begin
        if (ll_r == 2'd0) begin
          cronly_nxt = (b == hrsp_pkg::CH_CR);
        end
        if (ll_r < 2'd2) begin
          ll_nxt = ll_r + 2'd1;
        end
        if (int'(hpos_r) < hrsp_pkg::HDR_LEN) begin
          if (b == hrsp_pkg::hdr_char(hpos_r)) begin
            hpos_nxt = hpos_r + 5'd1;
            if (int'(hpos_r) == hrsp_pkg::HDR_LEN - 1) begin
              chunked_nxt = 1'b1;
            end
          end else begin
            hpos_nxt = hrsp_pkg::MATCH_FAIL;
          end
        end
      end
    end

    case (phase_r)
      PH_VERSION, PH_CODE, PH_REASON: begin
        if (b == hrsp_pkg::CH_LF) begin
          have = 1'b1;
          kind = hrsp_pkg::KIND_STATUS;
          if (lf_empty) begin
            crem_nxt  = '0;
            phase_nxt = chunked_r ? PH_SIZE : PH_BODY;
          end else begin
            phase_nxt = PH_HEADERS;
          end
        end else if (b == hrsp_pkg::CH_SP) begin
          if (phase_r == PH_VERSION) begin
            phase_nxt = PH_CODE;
          end else if (phase_r == PH_CODE) begin
            seen_nxt  = 1'b1;
            phase_nxt = PH_REASON;
          end
        end else if (phase_r == PH_CODE && dcnt_r != hrsp_pkg::DIGITS_STOPPED) begin
          // Status digits
          if (b < hrsp_pkg::CH_0 || b > hrsp_pkg::CH_9) begin
            dcnt_nxt = hrsp_pkg::DIGITS_STOPPED;
          end else if (int'(dcnt_r) < hrsp_pkg::CODE_DIGITS) begin
            code_nxt = code_ext[hrsp_pkg::CODE_W-1:0];
            dcnt_nxt = dcnt_r + 3'd1;
          end else begin
            code_nxt = hrsp_pkg::CODE_W'(hrsp_pkg::CODE_MAX);
          end
        end
      end
      PH_HEADERS: begin
        if (b == hrsp_pkg::CH_LF && lf_empty) begin
          crem_nxt  = '0;
          phase_nxt = chunked_r ? PH_SIZE : PH_BODY;
        end
      end
      PH_BODY: begin
        have = 1'b1;
        kind = hrsp_pkg::KIND_CONTENT;
        ob   = b;
      end
      PH_SIZE, PH_DATA: begin
        // Chunk decoding; a byte that ends one sub-step may start the next
        go = 1'b1;
        for (int p = 0; p < hrsp_pkg::CHUNK_PASSES; p++) begin
          if (go) begin
            go = 1'b0;
            if (ph == PH_SIZE) begin
              if (ll == 2'd0) begin
                if (hx[4]) begin
                  cr = hrsp_pkg::CR_W'(hx[3:0]);
                  ll = 2'd1;
                end
              end else if (ll == 2'd1 && hx[4]) begin
                cr = hrsp_pkg::size_step(cr, hx[3:0]);
              end else if (ll == 2'd1 && b == hrsp_pkg::CH_CR) begin
                ll = 2'd2;
              end else begin
                ll = 2'd0;
                ph = (cr == '0) ? PH_DONE : PH_DATA;
                go = (b != hrsp_pkg::CH_LF) && (cr != '0);
              end
            end else if (ph == PH_DATA) begin
              if (ll == 2'd0) begin
                have = 1'b1;
                kind = hrsp_pkg::KIND_CONTENT;
                ob   = b;
                cr   = cr - 1'b1;
                if (cr == '0) begin
                  ll = 2'd1;
                end
              end else if (ll == 2'd1 && b == hrsp_pkg::CH_CR) begin
                ll = 2'd2;
              end else begin
                ph = PH_SIZE;
                ll = 2'd0;
                go = (b != hrsp_pkg::CH_LF);
              end
            end
          end
        end
        phase_nxt = ph;
        ll_nxt    = ll;
        crem_nxt  = cr;
      end
      default: begin
        // after the zero chunk: bytes are dropped
      end
    endcase

    // Last byte of a response always yields a result
    if (item.last && !have) begin
      have = 1'b1;
      kind = ((phase_nxt == PH_VERSION) || (phase_nxt == PH_CODE) || (phase_nxt == PH_REASON))
             ? hrsp_pkg::KIND_STATUS : hrsp_pkg::KIND_END;
    end

    res.have         = en && have;
    res.kind         = kind;
    res.status       = (kind != hrsp_pkg::KIND_STATUS) ? '0 :
                       (seen_nxt ? $signed({1'b0, code_nxt}) : '1);
    res.content_byte = (kind == hrsp_pkg::KIND_CONTENT) ? ob : 8'd0;
    res.final_res    = item.last;
  end

  // State registers; the last byte returns everything to reset
  always_ff @(posedge clk) begin
    if (!rst_n || (en && item.last)) begin
      phase_r   <= PH_VERSION;
      code_r    <= '0;
      seen_r    <= 1'b0;
      hpos_r    <= 5'd0;
      ll_r      <= 2'd0;
      cronly_r  <= 1'b0;
      chunked_r <= 1'b0;
      crem_r    <= '0;
      dcnt_r    <= 3'd0;
    end else if (en) begin
      phase_r   <= phase_nxt;
      code_r    <= code_nxt;
      seen_r    <= seen_nxt;
      hpos_r    <= hpos_nxt;
      ll_r      <= ll_nxt;
      cronly_r  <= cronly_nxt;
      chunked_r <= chunked_nxt;
      crem_r    <= crem_nxt;
      dcnt_r    <= dcnt_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  // Match position is a prefix length or the fail mark
  a_hpos_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(hpos_r) <= hrsp_pkg::HDR_LEN) || (hpos_r == hrsp_pkg::MATCH_FAIL))
    else $error("header match position out of range");

  // Digit counter stays within the status code digit count or is stopped
  a_dcnt_legal: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(dcnt_r) <= hrsp_pkg::CODE_DIGITS) || (dcnt_r == hrsp_pkg::DIGITS_STOPPED))
    else $error("status digit counter out of range");

  // The last byte leaves the parser at the start of a new response
  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (en && item.last) |=> (phase_r == PH_VERSION && !chunked_r && crem_r == '0))
    else $error("state not cleared after end of response");

  // Content comes only from the body phases
  a_content_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (res.have && res.kind == hrsp_pkg::KIND_CONTENT) |->
      (phase_r == PH_BODY || phase_r == PH_SIZE || phase_r == PH_DATA))
    else $error("content byte outside the body");

  // A status report comes only from the status line
  a_status_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (res.have && res.kind == hrsp_pkg::KIND_STATUS) |->
      (phase_r == PH_VERSION || phase_r == PH_CODE || phase_r == PH_REASON))
    else $error("status report after the status line");
`endif

endmodule

// ----- src/hrsp_out_stage.sv -----
// Result register of the parser; tells the upstream stages when it can take a result.
// Depends on hrsp_pkg (res_t, STAT_W).

module hrsp_out_stage (
  input  logic                               clk,
  input  logic                               rst_n,
  input  hrsp_pkg::res_t                     res,
  output logic                               room,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         out_kind,
  output logic signed [hrsp_pkg::STAT_W-1:0] out_status,
  output logic [7:0]                         out_content_byte,
  output logic                               out_final_res
);

  logic                               vld_r;
  logic [1:0]                         kind_r;
  logic signed [hrsp_pkg::STAT_W-1:0] stat_r;
  logic [7:0]                         byte_r;
  logic                               fin_r;

  // Free when empty or being drained this cycle
  assign room = !vld_r || !out_stall;

  // Valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (room) begin
      vld_r <= res.have;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (room && res.have) begin
      kind_r <= res.kind;
      stat_r <= res.status;
      byte_r <= res.content_byte;
      fin_r  <= res.final_res;
    end
  end

  assign out_valid        = vld_r;
  assign out_kind         = kind_r;
  assign out_status       = stat_r;
  assign out_content_byte = byte_r;
  assign out_final_res    = fin_r;

endmodule

// ----- src/http_response_stream_parser_core.sv -----
// Top level of the HTTP response stream parser with chunked transfer decoding.
// Depends on hrsp_pkg, hrsp_in_stage, hrsp_parser and hrsp_out_stage.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-----------------------------------------
//  in_      | input     | in_valid / in_stall   | data_byte[7:0], end_of_response
//  out_     | output    | out_valid / out_stall | kind[1:0], status[10:0] s,
//           |           |                      | content_byte[7:0], final_res
//
// One byte per clock while not stalled: input register, parse logic, result register.
// A byte's result (if any) goes into the result register when the byte leaves the input register.
// Synchronous active-low reset clears the parser state and both valid flags.
// out_stall holds the result register; the input register keeps taking bytes
// until it too is full, then in_stall rises.

module http_response_stream_parser_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_data_byte,
  input  logic                               in_end_of_response,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         out_kind,
  output logic signed [hrsp_pkg::STAT_W-1:0] out_status,
  output logic [7:0]                         out_content_byte,
  output logic                               out_final_res
);

  hrsp_pkg::item_t item;
  hrsp_pkg::res_t  res;
  logic            room;

  hrsp_in_stage u_in (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_end_of_response (in_end_of_response),
    .room               (room),
    .item               (item)
  );

  hrsp_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (item),
    .room  (room),
    .res   (res)
  );

  hrsp_out_stage u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .res              (res),
    .room             (room),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_status       (out_status),
    .out_content_byte (out_content_byte),
    .out_final_res    (out_final_res)
  );

endmodule
